// ===== design/mexp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Modular exponentiation package
// Shared types and constants for the modular exponentiation unit.
// ----------------------------------------------------------------------------
package mexp_pkg;

  // Width of every payload field and of the configuration data bus.
  localparam int DATA_BITS = 32;

  // Byte address width of the configuration port: two 32-bit registers.
  localparam int ADDR_BITS = 3;

  // Register indexes (word address, paddr[2]).
  localparam logic [0:0] REG_MODULUS   = 1'b0;
  localparam logic [0:0] REG_GENERATOR = 1'b1;

  // Reset values of the registers.
  localparam logic [DATA_BITS-1:0] MODULUS_RESET   = 32'd23;
  localparam logic [DATA_BITS-1:0] GENERATOR_RESET = 32'd5;

  // Operations of the shared modular arithmetic unit.
  typedef enum logic {
    OP_MUL,   // a * b mod m, with a and b below m
    OP_RED    // a mod m
  } mexp_op_e;

  // Command from the sequencer to the arithmetic unit.
  typedef struct packed {
    logic     start;
    mexp_op_e op;
  } mexp_cmd_t;

endpackage
`default_nettype wire

// ===== design/mexp_mulmod.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Modular multiply and reduce unit
// Bit-serial a * b mod m (shift and add) or a mod m (shift and subtract),
// one bit per cycle.
// ----------------------------------------------------------------------------
module mexp_mulmod #(
  parameter int W = 32
) (
  input  wire                logic clk_i,
  input  wire                logic rst_ni,
  input  mexp_pkg::mexp_cmd_t      cmd_i,
  input  wire logic [W-1:0]        a_i,
  input  wire logic [W-1:0]        b_i,
  input  wire logic [W-1:0]        m_i,
  output logic                     done_o,
  output logic [W-1:0]             result_o
);

  localparam int CNT_BITS = $clog2(W + 1);

  // (a + b) mod m for a, b below m, without overflow.
  function automatic logic [W-1:0] add_mod(input logic [W-1:0] a,
                                           input logic [W-1:0] b,
                                           input logic [W-1:0] m);
    logic [W-1:0] room;
    room = m - b;
    if (a >= room) begin
      return a - room;
    end
    return a + b;
  endfunction

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [CNT_BITS-1:0] cnt_q, cnt_d;
  mexp_pkg::mexp_op_e  op_q, op_d;
  logic [W-1:0]        r_q, r_d;
  logic [W-1:0]        x_q, x_d;
  logic [W-1:0]        y_q, y_d;
  logic [W:0]          red_t;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    op_d   = op_q;
    r_d    = r_q;
    x_d    = x_q;
    y_d    = y_q;
    red_t  = {r_q, x_q[W-1]};
    if (cmd_i.start) begin
      busy_d = 1'b1;
      cnt_d  = CNT_BITS'(W);
      op_d   = cmd_i.op;
      r_d    = '0;
      x_d    = a_i;
      y_d    = b_i;
    end else if (busy_q) begin
      unique case (op_q)
        mexp_pkg::OP_MUL: begin
          r_d = y_q[0] ? add_mod(r_q, x_q, m_i) : r_q;
          x_d = add_mod(x_q, x_q, m_i);
          y_d = y_q >> 1;
        end
        mexp_pkg::OP_RED: begin
          // The partial remainder stays below m, so one subtract suffices.
          r_d = (red_t >= {1'b0, m_i}) ? W'(red_t - {1'b0, m_i}) : W'(red_t);
          x_d = x_q << 1;
        end
        default: ;
      endcase
      cnt_d = cnt_q - CNT_BITS'(1);
      if (cnt_q == CNT_BITS'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      op_q   <= mexp_pkg::OP_MUL;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
      op_q   <= op_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q <= r_d;
    x_q <= x_d;
    y_q <= y_d;
  end

  assign done_o   = done_q;
  assign result_o = r_q;

`ifndef SYNTHESIS
  // A new command never arrives while an operation is in flight.
  a_no_start_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.start |-> !busy_q)
    else $error("mulmod started while busy");
`endif

endmodule
`default_nettype wire

// ===== design/modular_exponentiation_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Modular exponentiation unit
// Computes base^exponent mod modulus by left-to-right square and multiply,
// with every product reduced by a shared bit-serial modular multiplier.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake               Payload
//  -------   ---------  ---------------------   ------------------------------
//  in        slave      in_valid_i/in_ready_o   kind_i, exponent_i, base_value_i
//  out       master     out_valid_o/out_ready_i power_mod_o
//  config    APB slave  psel/penable/pready     paddr, pwrite, pwdata, prdata
//
// A request first has its base reduced mod the modulus, then each of the W
// exponent bits costs one modular square and, for a set bit, one modular
// multiply, each on the single shared multiplier. A request takes longer the
// more exponent bits are set; a modulus below two skips the multiplier and
// gives result 0. in_ready_o is high only while the sequencer is idle. A
// finished result waits in the output register while the next request is
// accepted; the sequencer stalls only if a second result is ready before the
// first one was taken. Reset restores modulus 23 and generator 5 and returns
// the sequencer to idle; there is no clearing pass.
//
module modular_exponentiation_unit #(
  parameter int WORD_BITS = 32
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // Request channel
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire logic                                kind_i,
  input  wire logic [mexp_pkg::DATA_BITS-1:0]      exponent_i,
  input  wire logic [mexp_pkg::DATA_BITS-1:0]      base_value_i,
  // Result channel
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic [mexp_pkg::DATA_BITS-1:0]           power_mod_o,
  // Configuration port
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [mexp_pkg::ADDR_BITS-1:0]      paddr,
  input  wire logic [mexp_pkg::DATA_BITS-1:0]      pwdata,
  output logic [mexp_pkg::DATA_BITS-1:0]           prdata,
  output logic                                     pready
);

  // Working width: all values are taken modulo 2^W, and never beyond 32 bits.
  localparam int W        = (WORD_BITS < mexp_pkg::DATA_BITS) ? WORD_BITS
                                                              : mexp_pkg::DATA_BITS;
  localparam int IDX_BITS = $clog2(W);

  typedef enum logic [2:0] {
    S_IDLE,   // waiting for a request
    S_RED,    // reducing the base mod the modulus
    S_SQR,    // squaring the accumulator
    S_MUL,    // multiplying the accumulator by the base
    S_OUT     // handing the result to the output register
  } state_e;

  state_e              state_q, state_d;
  logic [W-1:0]        modulus_q, modulus_d;
  logic [W-1:0]        generator_q, generator_d;
  logic [W-1:0]        exp_q, exp_d;
  logic [W-1:0]        base_q, base_d;
  logic [W-1:0]        acc_q, acc_d;
  logic [W-1:0]        opa_q, opa_d;
  logic [W-1:0]        opb_q, opb_d;
  logic [IDX_BITS-1:0] idx_q, idx_d;
  mexp_pkg::mexp_cmd_t cmd_q, cmd_d;
  logic                out_valid_q, out_valid_d;
  logic [W-1:0]        power_mod_q, power_mod_d;

  logic                cfg_write;
  logic                unit_done;
  logic [W-1:0]        unit_result;
  logic                advance;
  logic [W-1:0]        advance_acc;

  mexp_mulmod #(
    .W (W)
  ) u_mulmod (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd_q),
    .a_i      (opa_q),
    .b_i      (opb_q),
    .m_i      (modulus_q),
    .done_o   (unit_done),
    .result_o (unit_result)
  );

  assign cfg_write = psel && penable && pwrite;

  always_comb begin
    state_d     = state_q;
    modulus_d   = modulus_q;
    generator_d = generator_q;
    exp_d       = exp_q;
    base_d      = base_q;
    acc_d       = acc_q;
    opa_d       = opa_q;
    opb_d       = opb_q;
    idx_d       = idx_q;
    cmd_d       = '{start: 1'b0, op: mexp_pkg::OP_MUL};
    out_valid_d = out_valid_q;
    power_mod_d = power_mod_q;
    advance     = 1'b0;
    advance_acc = unit_result;

    // The user must issue configuration writes only while the sequencer is idle; the block does not enforce it.
    if (cfg_write) begin
      unique case (paddr[mexp_pkg::ADDR_BITS-1:2])
        mexp_pkg::REG_MODULUS:   modulus_d   = W'(pwdata);
        mexp_pkg::REG_GENERATOR: generator_d = W'(pwdata);
        default: ;
      endcase
    end

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          exp_d  = W'(exponent_i);
          base_d = kind_i ? W'(base_value_i) : generator_q;
          if (modulus_q < W'(2)) begin
            // A modulus of zero or one yields a zero result.
            acc_d   = '0;
            state_d = S_OUT;
          end else begin
            opa_d   = base_d;
            cmd_d   = '{start: 1'b1, op: mexp_pkg::OP_RED};
            state_d = S_RED;
          end
        end
      end
      S_RED: begin
        if (unit_done) begin
          // Start from 1 and square it on the way in; 1 * 1 stays 1.
          base_d  = unit_result;
          acc_d   = W'(1);
          opa_d   = W'(1);
          opb_d   = W'(1);
          idx_d   = IDX_BITS'(W - 1);
          cmd_d   = '{start: 1'b1, op: mexp_pkg::OP_MUL};
          state_d = S_SQR;
        end
      end
      S_SQR: begin
        if (unit_done) begin
          acc_d = unit_result;
          if (exp_q[W-1]) begin
            opa_d   = unit_result;
            opb_d   = base_q;
            cmd_d   = '{start: 1'b1, op: mexp_pkg::OP_MUL};
            state_d = S_MUL;
          end else begin
            advance = 1'b1;
          end
        end
      end
      S_MUL: begin
        if (unit_done) begin
          acc_d   = unit_result;
          advance = 1'b1;
        end
      end
      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          power_mod_d = acc_q;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    // Move on to the next exponent bit, or finish after the last one.
    if (advance) begin
      if (idx_q == '0) begin
        state_d = S_OUT;
      end else begin
        idx_d   = idx_q - IDX_BITS'(1);
        exp_d   = exp_q << 1;
        opa_d   = advance_acc;
        opb_d   = advance_acc;
        cmd_d   = '{start: 1'b1, op: mexp_pkg::OP_MUL};
        state_d = S_SQR;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      modulus_q   <= W'(mexp_pkg::MODULUS_RESET);
      generator_q <= W'(mexp_pkg::GENERATOR_RESET);
      idx_q       <= '0;
      cmd_q       <= '{start: 1'b0, op: mexp_pkg::OP_MUL};
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      modulus_q   <= modulus_d;
      generator_q <= generator_d;
      idx_q       <= idx_d;
      cmd_q       <= cmd_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    exp_q       <= exp_d;
    base_q      <= base_d;
    acc_q       <= acc_d;
    opa_q       <= opa_d;
    opb_q       <= opb_d;
    power_mod_q <= power_mod_d;
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign power_mod_o = mexp_pkg::DATA_BITS'(power_mod_q);
  assign pready      = 1'b1;
  assign prdata      = (paddr[mexp_pkg::ADDR_BITS-1:2] == mexp_pkg::REG_GENERATOR)
                       ? mexp_pkg::DATA_BITS'(generator_q)
                       : mexp_pkg::DATA_BITS'(modulus_q);

`ifndef SYNTHESIS
  // The multiplier only reports completion while the sequencer waits for it.
  a_done_in_compute : assert property (@(posedge clk_i) disable iff (!rst_ni)
    unit_done |-> (state_q == S_RED || state_q == S_SQR || state_q == S_MUL))
    else $error("multiplier done outside a compute state");

  // An accepted request closes the input until its result is handed over.
  a_busy_after_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("request accepted while the previous one is in flight");

  // Every result with a valid modulus is fully reduced.
  a_result_reduced : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT && (!out_valid_q || out_ready_i) && modulus_q >= W'(2))
    |=> (power_mod_q < modulus_q))
    else $error("result not reduced below the modulus");
`endif

endmodule
`default_nettype wire

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modular exponentiation unit testbench
// Drives public value and shared secret requests through the request channel,
// predicts every power in the bench and compares each result in order.
// ----------------------------------------------------------------------------
module tb_top;

  // Request kinds: the base is the configured generator or the supplied value.
  localparam logic KIND_PUBLIC = 1'b0;
  localparam logic KIND_SHARED = 1'b1;

  // Length of the single long result stall. It covers two full
  // exponentiations, so the output register fills and the input stalls.
  localparam int LONG_HOLD_CYCLES = 8000;

  // Cycles allowed after the last result for a stray result to show up.
  localparam int TAIL_CYCLES = 2500;

  localparam int RANDOM_PHASES    = 6;
  localparam int ITEMS_PER_PHASE  = 41;

  typedef struct packed {
    logic                           kind;
    logic [mexp_pkg::DATA_BITS-1:0] exponent;
    logic [mexp_pkg::DATA_BITS-1:0] base_value;
  } dh_request_t;

  typedef struct packed {
    dh_request_t                    req;
    logic [mexp_pkg::DATA_BITS-1:0] power;
  } power_expectation_t;

  // Every input of the block starts at a known value.
  logic                           clk_i        = 1'b0;
  logic                           rst_ni       = 1'b0;
  logic                           in_valid_i   = 1'b0;
  logic                           kind_i       = 1'b0;
  logic [mexp_pkg::DATA_BITS-1:0] exponent_i   = '0;
  logic [mexp_pkg::DATA_BITS-1:0] base_value_i = '0;
  logic                           out_ready_i  = 1'b0;
  logic                           psel         = 1'b0;
  logic                           penable      = 1'b0;
  logic                           pwrite       = 1'b0;
  logic [mexp_pkg::ADDR_BITS-1:0] paddr        = '0;
  logic [mexp_pkg::DATA_BITS-1:0] pwdata       = '0;

  logic                           in_ready_o;
  logic                           out_valid_o;
  logic [mexp_pkg::DATA_BITS-1:0] power_mod_o;
  logic [mexp_pkg::DATA_BITS-1:0] prdata;
  logic                           pready;

  // Bench copy of the configuration registers, starting at the reset values.
  logic [mexp_pkg::DATA_BITS-1:0] cfg_modulus   = mexp_pkg::MODULUS_RESET;
  logic [mexp_pkg::DATA_BITS-1:0] cfg_generator = mexp_pkg::GENERATOR_RESET;

  dh_request_t        pending_requests[$];
  power_expectation_t expected_powers[$];

  int requests_queued   = 0;
  int requests_accepted = 0;
  int results_checked   = 0;
  int register_writes   = 0;
  int error_count       = 0;

  int sender_idle_pct   = 0;
  int receiver_idle_pct = 0;

  logic hold_armed       = 1'b0;
  logic hold_done        = 1'b0;
  int   hold_cycles_left = 0;

  modular_exponentiation_unit #(
    .WORD_BITS (mexp_pkg::DATA_BITS)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .kind_i       (kind_i),
    .exponent_i   (exponent_i),
    .base_value_i (base_value_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .power_mod_o  (power_mod_o),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #10 clk_i = ~clk_i;

  // Left-to-right square and multiply. Both factors stay below 2^32, so each
  // product fits in 64 bits and is reduced at once. A modulus of zero or one
  // gives zero; an exponent of zero leaves the accumulator at one.
  function automatic logic [mexp_pkg::DATA_BITS-1:0] mod_power(
    input logic [mexp_pkg::DATA_BITS-1:0] base,
    input logic [mexp_pkg::DATA_BITS-1:0] exponent,
    input logic [mexp_pkg::DATA_BITS-1:0] modulus);
    longint unsigned m;
    longint unsigned b;
    longint unsigned acc;
    if (modulus < 2) return '0;
    m   = modulus;
    b   = base % m;
    acc = 1;
    for (int i = mexp_pkg::DATA_BITS - 1; i >= 0; i--) begin
      acc = (acc * acc) % m;
      if (exponent[i]) acc = (acc * b) % m;
    end
    return acc[mexp_pkg::DATA_BITS-1:0];
  endfunction

  // Request driver. When the held request is taken, its power is predicted
  // with the configuration in force; a new request may be offered at the
  // same clock edge unless the sender decides to idle.
  always @(posedge clk_i) begin
    dh_request_t        next_req;
    power_expectation_t entry;
    logic               offer;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      offer = in_valid_i;
      if (in_valid_i && in_ready_o) begin
        entry.req.kind       = kind_i;
        entry.req.exponent   = exponent_i;
        entry.req.base_value = base_value_i;
        entry.power = mod_power((kind_i == KIND_SHARED) ? base_value_i : cfg_generator,
                                exponent_i, cfg_modulus);
        expected_powers.push_back(entry);
        requests_accepted++;
        offer = 1'b0;
      end
      if (!offer && pending_requests.size() != 0 &&
          $urandom_range(99) >= sender_idle_pct) begin
        next_req = pending_requests.pop_front();
        kind_i       <= next_req.kind;
        exponent_i   <= next_req.exponent;
        base_value_i <= next_req.base_value;
        offer = 1'b1;
      end
      in_valid_i <= offer;
    end
  end

  // One long result stall, counted here once the stimulus arms it.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      hold_cycles_left <= 0;
    end else if (hold_armed && !hold_done) begin
      hold_cycles_left <= LONG_HOLD_CYCLES;
      hold_done        <= 1'b1;
    end else if (hold_cycles_left != 0) begin
      hold_cycles_left <= hold_cycles_left - 1;
    end
  end

  // Result monitor: every accepted result must match the oldest prediction.
  always @(posedge clk_i) begin
    power_expectation_t oldest;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_powers.size() == 0) begin
          $display("%0t: result with no request pending: power_mod actual %h",
                   $time, power_mod_o);
          error_count++;
        end else begin
          oldest = expected_powers.pop_front();
          if (power_mod_o !== oldest.power) begin
            $display("%0t: power_mod mismatch (kind %0d exp %h base %h): expected %h actual %h",
                     $time, oldest.req.kind, oldest.req.exponent, oldest.req.base_value,
                     oldest.power, power_mod_o);
            error_count++;
          end
          results_checked++;
        end
      end
      out_ready_i <= (hold_cycles_left == 0) && ($urandom_range(99) >= receiver_idle_pct);
    end
  end

  task automatic queue_request(input logic kind,
                               input logic [mexp_pkg::DATA_BITS-1:0] exponent,
                               input logic [mexp_pkg::DATA_BITS-1:0] base_value);
    dh_request_t req;
    req.kind       = kind;
    req.exponent   = exponent;
    req.base_value = base_value;
    pending_requests.push_back(req);
    requests_queued++;
  endtask

  // The stimulus waits until every queued request has returned its result.
  task automatic drain_results();
    while (pending_requests.size() != 0 || results_checked != requests_queued)
      @(posedge clk_i);
  endtask

  // APB write followed by a read back of the same register. The block must
  // be idle when this is called.
  task automatic write_register(input logic [0:0] idx,
                                input logic [mexp_pkg::DATA_BITS-1:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    // The register takes the value at this edge.
    if (idx == mexp_pkg::REG_MODULUS) cfg_modulus = value;
    else cfg_generator = value;
    register_writes++;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata !== value) begin
      $display("%0t: register %0d read back: expected %h actual %h",
               $time, idx, value, prdata);
      error_count++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Stimulus: directed corners under several register settings, then random
  // phases with the idle pattern changing as the run goes on.
  initial begin
    logic [mexp_pkg::DATA_BITS-1:0] new_modulus;
    logic [mexp_pkg::DATA_BITS-1:0] exponent;
    logic [mexp_pkg::DATA_BITS-1:0] base;
    logic                           kind;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    sender_idle_pct   = 27;
    receiver_idle_pct = 75;

    // Reset values: modulus 23, generator 5.
    queue_request(KIND_PUBLIC, 32'h0000_0000, 32'h0);
    queue_request(KIND_PUBLIC, 32'h0000_0001, 32'h0);
    queue_request(KIND_PUBLIC, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_request(KIND_SHARED, 32'h0000_0000, 32'h0000_0000);
    queue_request(KIND_SHARED, 32'h0000_0007, 32'h0000_0000);
    queue_request(KIND_SHARED, 32'h0000_0003, 32'd23);
    queue_request(KIND_SHARED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_request(KIND_SHARED, 32'h0000_0002, 32'd22);
    drain_results();

    // All-ones modulus and generator: the generator reduces to zero.
    write_register(mexp_pkg::REG_MODULUS,   32'hFFFF_FFFF);
    write_register(mexp_pkg::REG_GENERATOR, 32'hFFFF_FFFF);
    queue_request(KIND_PUBLIC, 32'h0000_0000, 32'h0);
    queue_request(KIND_PUBLIC, 32'h0000_0001, 32'h0);
    queue_request(KIND_SHARED, 32'hFFFF_FFFF, 32'hFFFF_FFFE);
    queue_request(KIND_SHARED, 32'h0000_0002, 32'h8000_0000);
    drain_results();

    // Largest 32-bit prime: Fermat's exponent gives one, a base equal to
    // the modulus gives zero.
    write_register(mexp_pkg::REG_MODULUS,   32'hFFFF_FFFB);
    write_register(mexp_pkg::REG_GENERATOR, 32'h0000_0002);
    queue_request(KIND_PUBLIC, 32'hFFFF_FFFA, 32'h0);
    queue_request(KIND_SHARED, 32'h0000_0005, 32'hFFFF_FFFB);
    queue_request(KIND_SHARED, 32'h5555_5555, 32'hAAAA_AAAA);
    drain_results();

    // Smallest legal modulus with a zero generator.
    write_register(mexp_pkg::REG_MODULUS,   32'd2);
    write_register(mexp_pkg::REG_GENERATOR, 32'd0);
    queue_request(KIND_PUBLIC, 32'h0000_0000, 32'h0);
    queue_request(KIND_PUBLIC, 32'h0000_0005, 32'h0);
    queue_request(KIND_SHARED, 32'hFFFF_FFFF, 32'h0000_0003);
    drain_results();

    // Modulus one and zero lie below the range; both must give zero.
    write_register(mexp_pkg::REG_MODULUS, 32'd1);
    queue_request(KIND_PUBLIC, 32'h0000_0000, 32'h0);
    queue_request(KIND_SHARED, 32'h0000_0003, 32'h0000_0005);
    drain_results();
    write_register(mexp_pkg::REG_MODULUS, 32'd0);
    queue_request(KIND_PUBLIC, 32'h0000_0000, 32'h0);
    queue_request(KIND_SHARED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    drain_results();

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      if (phase == 2) begin
        sender_idle_pct   = 75;
        receiver_idle_pct = 27;
      end
      if (phase == 4) begin
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
      end
      case ($urandom_range(3))
        0:       new_modulus = $urandom_range(100, 2);
        1:       new_modulus = 32'hFFFF_FFFB;
        2:       new_modulus = $urandom() | 32'h8000_0001;
        default: new_modulus = $urandom_range(32'h0000_FFFF, 2);
      endcase
      write_register(mexp_pkg::REG_MODULUS,   new_modulus);
      write_register(mexp_pkg::REG_GENERATOR, $urandom());
      // The first random phase runs into the long result stall.
      if (phase == 0) hold_armed = 1'b1;

      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        kind = $urandom_range(1);
        case ($urandom_range(7))
          0:       exponent = '0;
          1:       exponent = '1;
          2:       exponent = $urandom_range(15);
          3:       exponent = cfg_modulus - 1;
          default: exponent = $urandom();
        endcase
        case ($urandom_range(3))
          0:       base = $urandom();
          1:       base = (cfg_modulus > 1) ? $urandom() % cfg_modulus : $urandom();
          // A partner's public value, as in a real key exchange.
          2:       base = mod_power(cfg_generator, $urandom(), cfg_modulus);
          // At or just above the modulus, so the block must reduce the base.
          default: base = cfg_modulus + $urandom_range(3);
        endcase
        queue_request(kind, exponent, base);
      end
      drain_results();
    end

    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Checked %0d results from %0d requests over %0d register writes.",
             results_checked, requests_accepted, register_writes);
    $display("Covered both kinds, zero and full exponents, unreduced bases, moduli 0 to 2^32-1.");
    if (error_count == 0) begin
      $display("modular_exponentiation_unit test passed");
    end else begin
      $display("modular_exponentiation_unit test failed");
    end
    $finish;
  end

  // Watchdog, several times the slowest correct run.
  initial begin
    #60ms;
    $display("modular_exponentiation_unit test failed");
    $finish;
  end

endmodule

// ===== modular_exponentiation_unit.f =====
design/mexp_pkg.sv
design/mexp_mulmod.sv
design/modular_exponentiation_unit.sv
test/tb_top.sv
